### sv/msbfs_pkg.sv
package msbfs_pkg;

  // Fixed field widths of the stream items
  localparam int FUNC_W = 3;
  localparam int VTX_W  = 10;
  localparam int CNT_W  = 11;

  // Function codes of an input item
  localparam logic [FUNC_W-1:0] FN_ADD_EDGE = 3'd0;
  localparam logic [FUNC_W-1:0] FN_MARK     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SEED     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RUN      = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY    = 3'd4;

  // Result kinds
  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register index decoded from the config address
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 11'd1024;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [VTX_W-1:0]  vertex;
    logic [VTX_W-1:0]  neighbor;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic             connected;
    logic [CNT_W-1:0] flagged_count;
    logic             overflow;
  } result_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EDGE_WR,
    ST_CLEAR,
    ST_SEED_RD,
    ST_SEED_CHK,
    ST_SEED_VIS,
    ST_POP,
    ST_HEAD,
    ST_EDGE,
    ST_TGT,
    ST_VISIT,
    ST_QUERY,
    ST_EMIT
  } state_t;

endpackage

### sv/msbfs_ram.sv
module msbfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // One registered read port, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/msbfs_core.sv
module msbfs_core #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 8192,
  parameter int MAX_SEEDS    = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [msbfs_pkg::CNT_W-1:0] vertex_count,
  input  msbfs_pkg::item_t        item,
  input  logic                    item_valid,
  output logic                    item_ready,
  output msbfs_pkg::result_t      res,
  output logic                    res_valid,
  input  logic                    res_ready
);

  import msbfs_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int ELW = $clog2(MAX_EDGES + 1);
  localparam int SAW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int SCW = $clog2(MAX_SEEDS + 1);
  localparam logic [ELW-1:0] NULL_LINK = ELW'(MAX_EDGES);
  localparam logic [VW-1:0]  SWEEP_END = VW'(MAX_VERTICES - 1);

  state_t state, state_next;

  // Control registers
  logic [VW-1:0]  sweep, sweep_next;
  logic [ELW-1:0] edge_fill, edge_fill_next;
  logic [SCW-1:0] seed_fill, seed_fill_next;
  logic [SCW-1:0] seed_idx, seed_idx_next;
  logic [VCW-1:0] q_front, q_front_next;
  logic [VCW-1:0] q_back, q_back_next;
  logic           dropped, dropped_next;

  // Payload registers
  logic [VW-1:0]  vtx;
  logic [VW-1:0]  nbr;
  logic           v_ok;
  logic           kind, kind_next;
  logic           conn, conn_next;

  // Memory ports
  logic           head_we, head_re;
  logic [VW-1:0]  head_waddr, head_raddr;
  logic [ELW-1:0] head_wdata, head_rdata;

  logic              edge_we, edge_re;
  logic [EAW-1:0]    edge_waddr, edge_raddr;
  logic [VW+ELW-1:0] edge_wdata, edge_rdata;

  logic          mark_we, mark_re, mark_wdata, mark_rdata;
  logic [VW-1:0] mark_waddr, mark_raddr;

  logic          flag_we, flag_re, flag_wdata, flag_rdata;
  logic [VW-1:0] flag_waddr, flag_raddr;

  logic           seed_we, seed_re;
  logic [SAW-1:0] seed_waddr, seed_raddr;
  logic [VW-1:0]  seed_rdata;

  logic          queue_we, queue_re;
  logic [VW-1:0] queue_waddr, queue_raddr, queue_wdata, queue_rdata;

  // Input decode
  logic          in_v_ok, in_nb_ok, accept;
  logic [VW-1:0] in_v, in_nb;

  // Visit unit: one compare and flag test shared by seeds and edges
  logic [VW-1:0]  vis_v;
  logic           vis_mark, vis_take;
  logic [VW-1:0]  edge_tgt;
  logic [ELW-1:0] edge_lnk;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign in_v_ok    = 32'(item.vertex) < MAX_VERTICES;
  assign in_nb_ok   = 32'(item.neighbor) < MAX_VERTICES;
  assign in_v       = VW'(item.vertex);
  assign in_nb      = VW'(item.neighbor);

  assign edge_tgt = edge_rdata[VW+ELW-1:ELW];
  assign edge_lnk = edge_rdata[ELW-1:0];
  assign vis_v    = (state == ST_SEED_VIS) ? seed_rdata : edge_tgt;
  assign vis_mark = (state == ST_SEED_VIS) ? mark_rdata : 1'b1;
  assign vis_take = (32'(vis_v) < 32'(vertex_count)) && vis_mark && !flag_rdata;

  assign res_valid         = (state == ST_EMIT);
  assign res.kind          = kind;
  assign res.connected     = conn;
  assign res.flagged_count = CNT_W'(q_back);
  assign res.overflow      = dropped;

  // Memories
  msbfs_ram #(.WIDTH(ELW), .DEPTH(MAX_VERTICES), .AW(VW)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
  );

  msbfs_ram #(.WIDTH(VW + ELW), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
  );

  msbfs_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES), .AW(VW)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .re(mark_re), .raddr(mark_raddr), .rdata(mark_rdata)
  );

  msbfs_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES), .AW(VW)) u_flag (
    .clk(clk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
    .re(flag_re), .raddr(flag_raddr), .rdata(flag_rdata)
  );

  msbfs_ram #(.WIDTH(VW), .DEPTH(MAX_SEEDS), .AW(SAW)) u_seed (
    .clk(clk), .we(seed_we), .waddr(seed_waddr), .wdata(in_v),
    .re(seed_re), .raddr(seed_raddr), .rdata(seed_rdata)
  );

  msbfs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES), .AW(VW)) u_queue (
    .clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
    .re(queue_re), .raddr(queue_raddr), .rdata(queue_rdata)
  );

  // State register and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep     <= '0;
      edge_fill <= '0;
      seed_fill <= '0;
      seed_idx  <= '0;
      q_front   <= '0;
      q_back    <= '0;
      dropped   <= 1'b0;
    end else begin
      state     <= state_next;
      sweep     <= sweep_next;
      edge_fill <= edge_fill_next;
      seed_fill <= seed_fill_next;
      seed_idx  <= seed_idx_next;
      q_front   <= q_front_next;
      q_back    <= q_back_next;
      dropped   <= dropped_next;
    end
  end

  // Latch item payload and result bits
  always_ff @(posedge clk) begin
    if (accept) begin
      vtx  <= in_v;
      nbr  <= in_nb;
      v_ok <= in_v_ok;
    end
    kind <= kind_next;
    conn <= conn_next;
  end

  // Sequencer: next state, counters and memory controls
  always_comb begin
    state_next     = state;
    sweep_next     = sweep;
    edge_fill_next = edge_fill;
    seed_fill_next = seed_fill;
    seed_idx_next  = seed_idx;
    q_front_next   = q_front;
    q_back_next    = q_back;
    dropped_next   = dropped;
    kind_next      = kind;
    conn_next      = conn;

    head_we    = 1'b0;
    head_waddr = sweep;
    head_wdata = NULL_LINK;
    head_re    = 1'b0;
    head_raddr = in_v;

    edge_we    = 1'b0;
    edge_waddr = edge_fill[EAW-1:0];
    edge_wdata = {nbr, head_rdata};
    edge_re    = 1'b0;
    edge_raddr = head_rdata[EAW-1:0];

    mark_we    = 1'b0;
    mark_waddr = sweep;
    mark_wdata = 1'b0;
    mark_re    = 1'b0;
    mark_raddr = seed_rdata;

    flag_we    = 1'b0;
    flag_waddr = sweep;
    flag_wdata = 1'b0;
    flag_re    = 1'b0;
    flag_raddr = in_v;

    seed_we    = 1'b0;
    seed_waddr = seed_fill[SAW-1:0];
    seed_re    = 1'b0;
    seed_raddr = seed_idx[SAW-1:0];

    queue_we    = 1'b0;
    queue_waddr = q_back[VW-1:0];
    queue_wdata = vis_v;
    queue_re    = 1'b0;
    queue_raddr = q_front[VW-1:0];

    case (state)
      // Clear list heads, marks and flags after reset
      ST_INIT: begin
        head_we = 1'b1;
        mark_we = 1'b1;
        flag_we = 1'b1;
        sweep_next = sweep + 1'b1;
        if (sweep == SWEEP_END) begin
          sweep_next = '0;
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          case (item.func)
            FN_ADD_EDGE: begin
              if (in_v_ok && in_nb_ok) begin
                if (edge_fill == NULL_LINK) begin
                  dropped_next = 1'b1;
                end else begin
                  head_re    = 1'b1;
                  state_next = ST_EDGE_WR;
                end
              end
            end
            FN_MARK: begin
              mark_we    = in_v_ok;
              mark_waddr = in_v;
              mark_wdata = 1'b1;
            end
            FN_SEED: begin
              if (in_v_ok) begin
                if (seed_fill == SCW'(MAX_SEEDS)) begin
                  dropped_next = 1'b1;
                end else begin
                  seed_we        = 1'b1;
                  seed_fill_next = seed_fill + 1'b1;
                end
              end
            end
            FN_RUN: begin
              sweep_next = '0;
              state_next = ST_CLEAR;
            end
            FN_QUERY: begin
              flag_re    = 1'b1;
              state_next = ST_QUERY;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      // Push the new edge at the head of its source list
      ST_EDGE_WR: begin
        edge_we        = 1'b1;
        head_we        = 1'b1;
        head_waddr     = vtx;
        head_wdata     = edge_fill;
        edge_fill_next = edge_fill + 1'b1;
        state_next     = ST_IDLE;
      end

      // Clear all reach flags before the walk
      ST_CLEAR: begin
        flag_we    = 1'b1;
        sweep_next = sweep + 1'b1;
        if (sweep == SWEEP_END) begin
          sweep_next    = '0;
          seed_idx_next = '0;
          q_front_next  = '0;
          q_back_next   = '0;
          state_next    = ST_SEED_RD;
        end
      end

      // Fetch the next seed
      ST_SEED_RD: begin
        if (seed_idx == seed_fill) begin
          state_next = ST_POP;
        end else begin
          seed_re       = 1'b1;
          seed_idx_next = seed_idx + 1'b1;
          state_next    = ST_SEED_CHK;
        end
      end

      // Look up the seed's mark and flag
      ST_SEED_CHK: begin
        mark_re    = 1'b1;
        flag_re    = 1'b1;
        flag_raddr = seed_rdata;
        state_next = ST_SEED_VIS;
      end

      ST_SEED_VIS: begin
        if (vis_take) begin
          flag_we     = 1'b1;
          flag_waddr  = vis_v;
          flag_wdata  = 1'b1;
          queue_we    = 1'b1;
          q_back_next = q_back + 1'b1;
        end
        state_next = ST_SEED_RD;
      end

      // Dequeue a vertex or finish the run
      ST_POP: begin
        if (q_front == q_back) begin
          kind_next  = KIND_RUN;
          conn_next  = 1'b0;
          state_next = ST_EMIT;
        end else begin
          queue_re     = 1'b1;
          q_front_next = q_front + 1'b1;
          state_next   = ST_HEAD;
        end
      end

      ST_HEAD: begin
        head_re    = 1'b1;
        head_raddr = queue_rdata;
        state_next = ST_EDGE;
      end

      // Start on the vertex's edge list
      ST_EDGE: begin
        if (head_rdata == NULL_LINK) begin
          state_next = ST_POP;
        end else begin
          edge_re    = 1'b1;
          state_next = ST_TGT;
        end
      end

      ST_TGT: begin
        flag_re    = 1'b1;
        flag_raddr = edge_tgt;
        state_next = ST_VISIT;
      end

      // Flag and queue the target, then follow the link
      ST_VISIT: begin
        if (vis_take) begin
          flag_we     = 1'b1;
          flag_waddr  = vis_v;
          flag_wdata  = 1'b1;
          queue_we    = 1'b1;
          q_back_next = q_back + 1'b1;
        end
        if (edge_lnk == NULL_LINK) begin
          state_next = ST_POP;
        end else begin
          edge_re    = 1'b1;
          edge_raddr = edge_lnk[EAW-1:0];
          state_next = ST_TGT;
        end
      end

      ST_QUERY: begin
        kind_next  = KIND_QUERY;
        conn_next  = v_ok && flag_rdata;
        state_next = ST_EMIT;
      end

      // Hold the result until the output stage takes it
      ST_EMIT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/multi_source_bfs_reachability.sv
// Mark and seed items are handled in ST_IDLE, add edge also in ST_EDGE_WR, a query in ST_QUERY.
// A run clears the reach flags in ST_CLEAR, takes each stored seed through ST_SEED_RD, ST_SEED_CHK
// and ST_SEED_VIS, each dequeued vertex through ST_POP, ST_HEAD and ST_EDGE and each edge walked
// through ST_TGT and ST_VISIT; each memory has one write and one registered read port. One item is
// in work at a time; the output register lets the next item in while a result waits. After reset the
// block clears list heads, marks and flags and accepts no item until done; vertex_count resets to 1024.
module multi_source_bfs_reachability #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 8192,
  parameter int MAX_SEEDS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [9:0] vertex, [19:10] neighbor, [23:20] zero
  input  logic [2:0]  s_tuser,   // [2:0] func
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] connected, [11:1] flagged_count, [12] overflow, [15:13] zero
  output logic [0:0]  m_tuser,   // [0] kind
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import msbfs_pkg::*;

  logic [CNT_W-1:0] vertex_count;
  item_t            item;
  result_t          res;
  logic             res_valid, res_ready;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vertex_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[CNT_W-1:0];
    end
  end

  // Unpack input item
  assign item.func     = s_tuser;
  assign item.vertex   = s_tdata[VTX_W-1:0];
  assign item.neighbor = s_tdata[2*VTX_W-1:VTX_W];

  msbfs_core #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES(MAX_EDGES),
    .MAX_SEEDS(MAX_SEEDS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .vertex_count(vertex_count),
    .item(item),
    .item_valid(s_tvalid),
    .item_ready(s_tready),
    .res(res),
    .res_valid(res_valid),
    .res_ready(res_ready)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {3'b000, res.overflow, res.flagged_count, res.connected};
      m_tuser <= res.kind;
    end
  end

endmodule
